[rtl/core/delta_sleep_queue_defines.svh]
// Assertion macros for the delta sleep queue.
`ifndef DELTA_SLEEP_QUEUE_DEFINES_SVH
`define DELTA_SLEEP_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define DSQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define DSQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define DSQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/core/dsq_pkg.sv]
// Types and constants of the delta sleep queue.
package dsq_pkg;

    localparam int DSQ_MAX_TASKS = 16;
    localparam int TASK_W        = 4;
    localparam int DELTA_W       = 32;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic [TASK_W-1:0]  task_t;
    typedef logic [DELTA_W-1:0] delta_t;

    typedef struct packed {
        task_t  id;
        delta_t delta;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS,
        ST_TK_RD,
        ST_TK_HEAD,
        ST_TK_NRD,
        ST_TK_NEXT,
        ST_TK_LAST
    } state_t;

endpackage

[rtl/core/delta_sleep_queue.sv]
// Delta-list timer queue of sleeping task ids.
//
// Input channel (s_*): one item is either an add (s_kind = 0) that queues
// s_task_id to sleep for s_sleep_ticks ticks, or a timer tick (s_kind = 1).
// Result channel (m_*): a tick that expires the head yields one item per
// woken task, in queue order; m_last marks the final one of that tick.
// Adds never produce results; an add to a full queue is dropped.
//
// Entries live in a single-port-write, registered-read memory laid out as a
// ring (head pointer + count); each entry holds its wait relative to the
// entry ahead of it. A small sequencer drives one subtract/compare unit.
// Busy time from the accept until s_ready rises: an add walks each entry it
// passes, then shifts each entry it moves; a tick decrements the head, or else
// emits every woken task in turn.
// s_ready is high only while the sequencer is idle: one item at a time.
// The result register decouples the sides; if m_ready is low the sequencer
// holds in place until the register frees up, nothing is lost.
// Reset (aresetn low, synchronous) empties the queue; memory is not cleared
// since only entries below the count are ever read.
module delta_sleep_queue #(
    parameter int MAX_TASKS = dsq_pkg::DSQ_MAX_TASKS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  dsq_pkg::task_t       s_task_id,
    input  dsq_pkg::delta_t      s_sleep_ticks,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dsq_pkg::task_t       m_woken_task,
    output logic                 m_last
);
    import dsq_pkg::*;

`include "delta_sleep_queue_defines.svh"

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    // entry storage
    entry_t          mem [MAX_TASKS];
    entry_t          rdata_reg;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   hd_reg, hd_next;      // ring head
    logic [IW-1:0]   pos_reg, pos_next;    // insert walk position
    logic [IW-1:0]   k_reg, k_next;        // shift index
    delta_t          wait_reg, wait_next;  // remaining wait of the add
    task_t           id_reg, id_next;
    task_t           cur_reg, cur_next;    // woken task pending emit

    logic            m_valid_reg, m_valid_next;
    task_t           m_task_reg, m_task_next;
    logic            m_last_reg, m_last_next;

    logic            out_free;
    logic            accept;
    delta_t          diff;
    logic            le;
    logic [IW-1:0]   pos_inc;
    logic [IW-1:0]   hd_inc;
    logic [IW-1:0]   last_idx;

    // logical index -> ring address
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                           input logic [IW-1:0] idx);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, idx};
        if (s >= (IW+1)'(MAX_TASKS)) begin
            s = s - (IW+1)'(MAX_TASKS);
        end
        return s[IW-1:0];
    endfunction

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_woken_task = m_task_reg;
    assign m_last       = m_last_reg;

    // the subtract/compare unit of the add walk
    assign le       = (rdata_reg.delta <= wait_reg);
    assign diff     = le ? (wait_reg - rdata_reg.delta) : (rdata_reg.delta - wait_reg);
    assign pos_inc  = pos_reg + IW'(1);
    assign hd_inc   = (hd_reg == IW'(MAX_TASKS - 1)) ? '0 : hd_reg + IW'(1);
    assign last_idx = IW'(count_reg - CW'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            hd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hd_reg      <= hd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        wait_reg   <= wait_next;
        id_reg     <= id_next;
        cur_reg    <= cur_next;
        m_task_reg <= m_task_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        hd_next      = hd_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        wait_next    = wait_reg;
        id_next      = id_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_task_next  = m_task_reg;
        m_last_next  = m_last_reg;
        rd_addr      = hd_reg;
        wr_en        = 1'b0;
        wr_addr      = hd_reg;
        wr_data      = rdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_ADD) begin
                        if (count_reg != CW'(MAX_TASKS)) begin
                            id_next    = s_task_id;
                            wait_next  = s_sleep_ticks;
                            pos_next   = '0;
                            state_next = ST_ADD_RD;
                        end
                    end else if (count_reg != '0) begin
                        state_next = ST_TK_RD;
                    end
                end
            end
            ST_ADD_RD: begin
                rd_addr = phys(hd_reg, pos_reg);
                if (CW'(pos_reg) == count_reg) begin
                    state_next = ST_INS;   // end of queue: append
                end else begin
                    state_next = ST_ADD_CMP;
                end
            end
            ST_ADD_CMP: begin
                if (le) begin
                    wait_next = diff;
                    pos_next  = pos_inc;
                    if (diff != '0) begin
                        state_next = ST_ADD_RD;
                    end else if (CW'(pos_inc) == count_reg) begin
                        state_next = ST_INS;
                    end else begin
                        k_next     = last_idx;
                        state_next = ST_SH_RD;
                    end
                end else begin
                    // new entry goes here; entry behind it loses the remainder
                    wr_en         = 1'b1;
                    wr_addr       = phys(hd_reg, pos_reg);
                    wr_data.id    = rdata_reg.id;
                    wr_data.delta = diff;
                    k_next        = last_idx;
                    state_next    = ST_SH_RD;
                end
            end
            ST_SH_RD: begin
                rd_addr    = phys(hd_reg, k_reg);
                state_next = ST_SH_WR;
            end
            ST_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = phys(hd_reg, k_reg + IW'(1));
                wr_data = rdata_reg;
                if (k_reg == pos_reg) begin
                    state_next = ST_INS;
                end else begin
                    k_next     = k_reg - IW'(1);
                    state_next = ST_SH_RD;
                end
            end
            ST_INS: begin
                wr_en         = 1'b1;
                wr_addr       = phys(hd_reg, pos_reg);
                wr_data.id    = id_reg;
                wr_data.delta = wait_reg;
                count_next    = count_reg + CW'(1);
                state_next    = ST_IDLE;
            end
            ST_TK_RD: begin
                state_next = ST_TK_HEAD;
            end
            ST_TK_HEAD: begin
                if (rdata_reg.delta > delta_t'(1)) begin
                    wr_en         = 1'b1;
                    wr_data.delta = rdata_reg.delta - delta_t'(1);
                    state_next    = ST_IDLE;
                end else begin
                    cur_next   = rdata_reg.id;
                    hd_next    = hd_inc;
                    count_next = count_reg - CW'(1);
                    state_next = ST_TK_NRD;
                end
            end
            ST_TK_NRD: begin
                if (count_reg == '0) begin
                    state_next = ST_TK_LAST;
                end else begin
                    state_next = ST_TK_NEXT;
                end
            end
            ST_TK_NEXT: begin
                if (rdata_reg.delta == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_task_next  = cur_reg;
                        m_last_next  = 1'b0;
                        cur_next     = rdata_reg.id;
                        hd_next      = hd_inc;
                        count_next   = count_reg - CW'(1);
                        state_next   = ST_TK_NRD;
                    end
                end else begin
                    state_next = ST_TK_LAST;
                end
            end
            ST_TK_LAST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_task_next  = cur_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DSQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_TASKS), "count over depth")
    `DSQ_ASSERT_IMPL(a_head_bound, aclk, aresetn, 1'b1, hd_reg <= IW'(MAX_TASKS - 1), "head out of range")
    `DSQ_ASSERT_NEXT(a_full_drop, aclk, aresetn, accept && s_kind == KIND_ADD && count_reg == CW'(MAX_TASKS), state_reg == ST_IDLE && $stable(count_reg), "add to full queue changed state")
    `DSQ_ASSERT_NEXT(a_empty_tick, aclk, aresetn, accept && s_kind == KIND_TICK && count_reg == '0, state_reg == ST_IDLE, "tick on empty queue not ignored")
    `DSQ_ASSERT_IMPL(a_burst_open, aclk, aresetn, m_valid && m_ready && !m_last, state_reg != ST_IDLE, "wake burst ended without last")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the delta sleep queue: directed table, random bursts, idling phases.
module tb_top;
    import dsq_pkg::*;

    localparam int MAX_TASKS    = DSQ_MAX_TASKS;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    // Sized to cover the worst add and a full wake.
    localparam int DRAIN_CYCLES = 4 * MAX_TASKS + 40;
    // Long receiver hold-off; a wake stalls once the result register is full and s_ready stays low meanwhile.
    localparam int PRESS_CYCLES = 400;
    // Watchdog limit for the whole run.
    localparam int LIMIT_CYCLES = 250000;

    // One input item, plus an optional typed-in expectation (directed rows only).
    typedef struct packed {
        logic       kind;
        task_t      id;
        delta_t     ticks;
        logic       typed;
        logic [1:0] n_typed;
        task_t      w0;
        task_t      w1;
    } sleep_req_t;

    typedef struct packed {
        task_t id;
        logic  last;
    } wake_t;

    typedef enum {
        PH_DIRECT,
        PH_FREE,
        PH_PRESS,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } tb_phase_t;

    localparam int DIR_ROWS = 25;

    // Directed table. Typed rows carry the wake list read straight off the spec;
    // all others are checked against the predictor.
    localparam sleep_req_t DIRECTED [DIR_ROWS] = '{
        // tick on an empty queue: nothing
        '{KIND_TICK, 4'd0,  32'd0,          1'b1, 2'd0, 4'd0, 4'd0},
        // two zero waits, second goes behind the first, both wake on one tick
        '{KIND_ADD,  4'd15, 32'd0,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd0,  32'd0,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_TICK, 4'd0,  32'd0,          1'b1, 2'd2, 4'd15, 4'd0},
        // max waits; the second lands with a zero delta behind the first
        '{KIND_ADD,  4'd5,  32'hFFFF_FFFF,  1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd6,  32'hFFFF_FFFF,  1'b0, 2'd0, 4'd0, 4'd0},
        // duplicate id, short wait: goes to the head, next delta shrinks
        '{KIND_ADD,  4'd5,  32'd2,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_TICK, 4'hF,  32'hFFFF_FFFF,  1'b1, 2'd0, 4'd0, 4'd0},
        // head delta of one expires
        '{KIND_TICK, 4'd0,  32'd0,          1'b1, 2'd1, 4'd5, 4'd0},
        // fill to capacity
        '{KIND_ADD,  4'd1,  32'd3,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd2,  32'd1,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd3,  32'd3,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd4,  32'd0,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd5,  32'd7,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd6,  32'd2,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd7,  32'd3,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd8,  32'd10,         1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd9,  32'd1,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd10, 32'd5,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd11, 32'd0,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd12, 32'd4,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd13, 32'd3,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_ADD,  4'd14, 32'd9,          1'b0, 2'd0, 4'd0, 4'd0},
        // queue full: dropped
        '{KIND_ADD,  4'd9,  32'd3,          1'b0, 2'd0, 4'd0, 4'd0},
        '{KIND_TICK, 4'd0,  32'd0,          1'b0, 2'd0, 4'd0, 4'd0}
    };

    logic   aclk;
    logic   aresetn       = 1'b0;
    logic   s_valid       = 1'b0;
    logic   s_ready;
    logic   s_kind        = KIND_ADD;
    task_t  s_task_id     = '0;
    delta_t s_sleep_ticks = '0;
    logic   m_valid;
    logic   m_ready       = 1'b0;
    task_t  m_woken_task;
    logic   m_last;

    delta_sleep_queue #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_task_id    (s_task_id),
        .s_sleep_ticks(s_sleep_ticks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_woken_task (m_woken_task),
        .m_last       (m_last)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Predicted sleep list: same delta layout as the block, head at index 0.
    task_t  pq_task  [MAX_TASKS];
    delta_t pq_delta [MAX_TASKS];
    int     pq_count = 0;

    sleep_req_t pending_items  [$];   // items waiting to go on the input bus
    wake_t      woken_expected [$];   // wakeups not yet seen on the output
    sleep_req_t on_bus;
    tb_phase_t  run_phase      = PH_DIRECT;
    int         mismatch_count = 0;
    int         press_cycles   = 0;

    // Applies one accepted item to the predicted list; on a wake, queues the
    // woken ids in order when record is set.
    task automatic sleep_queue_step(input sleep_req_t req, input bit record);
        int     pos;
        int     k;
        int     n;
        delta_t rem;
        bit     walking;
        wake_t  w;
        if (req.kind == KIND_ADD) begin
            if (pq_count < MAX_TASKS) begin
                pos     = 0;
                rem     = req.ticks;
                walking = 1'b1;
                // walk while the entry fits in the remaining wait; stop at zero
                while (walking && pos < pq_count && pq_delta[pos] <= rem) begin
                    rem = rem - pq_delta[pos];
                    pos++;
                    if (rem == 0) walking = 1'b0;
                end
                if (pos < pq_count) pq_delta[pos] = pq_delta[pos] - rem;
                for (k = pq_count; k > pos; k--) begin
                    pq_task[k]  = pq_task[k-1];
                    pq_delta[k] = pq_delta[k-1];
                end
                pq_task[pos]  = req.id;
                pq_delta[pos] = rem;
                pq_count++;
            end
        end else if (pq_count != 0) begin
            if (pq_delta[0] > 1) begin
                pq_delta[0] = pq_delta[0] - 1'b1;
            end else begin
                // head expires (0 or 1), along with every zero delta behind it
                n = 1;
                while (n < pq_count && pq_delta[n] == 0) n++;
                for (k = 0; k < n; k++) begin
                    w.id   = pq_task[k];
                    w.last = (k + 1 == n);
                    if (record) woken_expected.push_back(w);
                end
                for (k = n; k < pq_count; k++) begin
                    pq_task[k-n]  = pq_task[k];
                    pq_delta[k-n] = pq_delta[k];
                end
                pq_count = pq_count - n;
            end
        end
    endtask

    function automatic sleep_req_t make_req(input logic kind, input task_t id,
                                            input delta_t ticks);
        sleep_req_t r;
        r       = '0;
        r.kind  = kind;
        r.id    = id;
        r.ticks = ticks;
        return r;
    endfunction

    // Mostly short waits so tasks actually wake; large_pct percent are full
    // 32-bit values (those effectively never expire).
    function automatic delta_t rand_ticks(input int large_pct);
        if ($urandom_range(0, 99) < large_pct) return delta_t'($urandom);
        if ($urandom_range(0, 3) == 0) return '0;
        return delta_t'($urandom_range(1, 6));
    endfunction

    // Random part: bursts of adds followed by bursts of ticks, with some
    // single noise items of any kind mixed in.
    task automatic plan_items(input int count);
        int made;
        int n_add;
        int n_tick;
        int j;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 99) < 10) begin
                pending_items.push_back(make_req(logic'($urandom_range(0, 1)),
                                                 task_t'($urandom), rand_ticks(20)));
                made++;
            end else begin
                n_add  = $urandom_range(1, 4);
                n_tick = $urandom_range(1, 7);
                for (j = 0; j < n_add; j++)
                    pending_items.push_back(make_req(KIND_ADD, task_t'($urandom),
                                                     rand_ticks(2)));
                // tick payload is don't-care; keep it random
                for (j = 0; j < n_tick; j++)
                    pending_items.push_back(make_req(KIND_TICK, task_t'($urandom),
                                                     delta_t'($urandom)));
                made += n_add + n_tick;
            end
        end
    endtask

    function automatic bit sender_idle();
        case (run_phase)
            PH_SEND_IDLE: return $urandom_range(0, 99) < 71;
            PH_BOTH:      return $urandom_range(0, 99) < 23;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (run_phase)
            PH_RECV_STALL: return $urandom_range(0, 99) < 71;
            PH_BOTH:       return $urandom_range(0, 99) < 23;
            default:       return 1'b0;
        endcase
    endfunction

    // Input side: predict on acceptance, then offer the next item or idle.
    // Valid stays up with a stable payload until the block takes the item.
    always @(posedge aclk) begin : item_driver
        wake_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sleep_queue_step(on_bus, !on_bus.typed);
                if (on_bus.typed) begin
                    // typed rows: expectation comes from the table itself
                    if (on_bus.n_typed != 0) begin
                        w.id   = on_bus.w0;
                        w.last = (on_bus.n_typed == 2'd1);
                        woken_expected.push_back(w);
                    end
                    if (on_bus.n_typed == 2'd2) begin
                        w.id   = on_bus.w1;
                        w.last = 1'b1;
                        woken_expected.push_back(w);
                    end
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && !sender_idle()) begin
                    on_bus = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_kind        <= on_bus.kind;
                    s_task_id     <= on_bus.id;
                    s_sleep_ticks <= on_bus.ticks;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each accepted item with the oldest expectation,
    // then choose m_ready for the next cycle. In the pressure phase ready is
    // held low until press_cycles reaches PRESS_CYCLES, counted here.
    always @(posedge aclk) begin : result_check
        wake_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (woken_expected.size() == 0) begin
                    $display("%0t: unexpected item: task %0d last %0b",
                             $time, m_woken_task, m_last);
                    mismatch_count++;
                end else begin
                    want = woken_expected.pop_front();
                    if (m_woken_task !== want.id) begin
                        $display("%0t: woken_task mismatch: expected %0d, got %0d",
                                 $time, want.id, m_woken_task);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, m_last);
                        mismatch_count++;
                    end
                end
            end
            if (run_phase == PH_PRESS && press_cycles < PRESS_CYCLES) begin
                press_cycles <= press_cycles + 1;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= !receiver_stall();
            end
        end
    end

    // Waits until every queued item has gone through the handshake.
    task automatic wait_sent();
        while (pending_items.size() != 0 || s_valid) @(negedge aclk);
    endtask

    initial begin : test_sequence
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) pending_items.push_back(DIRECTED[r]);
        wait_sent();

        // phases are switched at the falling edge, away from the sampling edge
        run_phase = PH_FREE;
        plan_items(40);
        wait_sent();

        run_phase = PH_PRESS;
        plan_items(30);
        wait_sent();

        run_phase = PH_SEND_IDLE;
        plan_items(40);
        wait_sent();

        run_phase = PH_RECV_STALL;
        plan_items(40);
        wait_sent();

        run_phase = PH_BOTH;
        plan_items(40);
        wait_sent();

        // all wakeups in, then give the block time to show any stray item
        while (woken_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
